FILE: hdl/epcal_pkg.sv
// ----------------------------------------------------------------------------
// Epoch-to-calendar shared definitions
// Constants for the reciprocal divisions, calendar bases and the table of
// cumulative month lengths used by the conversion pipeline.
// ----------------------------------------------------------------------------
package epcal_pkg;

    // Seconds per day is 2^7 * 675: the low seven bits split off by a shift,
    // the rest is divided by 675 with a reciprocal that rounds down.
    localparam int          DAY_LO_BITS    = 7;
    localparam logic [24:0] DAY_RECIP      = 25'd25451658;  // floor(2^34 / 675)
    localparam int          DAY_SHIFT      = 34;
    localparam logic [9:0]  DAY_HI_DIV     = 10'd675;

    // Four-year cycles of 1461 days.
    localparam logic [13:0] CYC_RECIP      = 14'd11483;     // floor(2^24 / 1461)
    localparam int          CYC_SHIFT      = 24;
    localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;

    // Day of week; day zero was a Thursday.
    localparam logic [15:0] WK_RECIP       = 16'd37449;     // floor(2^18 / 7)
    localparam int          WK_SHIFT       = 18;
    localparam logic [2:0]  DAYS_PER_WEEK  = 3'd7;
    localparam logic [14:0] WK_OFFSET      = 15'd4;

    // Time of day.
    localparam logic [10:0] HR_RECIP       = 11'd1165;      // floor(2^22 / 3600)
    localparam int          HR_SHIFT       = 22;
    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
    localparam logic [10:0] MIN_RECIP      = 11'd1092;      // floor(2^16 / 60)
    localparam int          MIN_SHIFT      = 16;
    localparam logic [5:0]  SECS_PER_MIN   = 6'd60;

    // Calendar bases.
    localparam logic [10:0] BASE_YEAR      = 11'd1970;
    localparam logic [8:0]  LEAP_DAY_INDEX = 9'd59;
    localparam logic [10:0] YEAR1_START    = 11'd365;
    localparam logic [10:0] YEAR2_START    = 11'd730;
    localparam logic [10:0] YEAR3_START    = 11'd1096;
    localparam logic [1:0]  LEAP_YEAR_IDX  = 2'd2;
    localparam logic [3:0]  MONTH_FEB      = 4'd1;
    localparam logic [3:0]  MONTH_DEC      = 4'd11;
    localparam logic [4:0]  FEB_LAST_DAY   = 5'd28;
    localparam int          MONTHS         = 12;

    // Day of a common year on which each month starts; entry 12 ends the year.
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] val;
        begin
            case (idx)
                4'd0:    val = 9'd0;
                4'd1:    val = 9'd31;
                4'd2:    val = 9'd59;
                4'd3:    val = 9'd90;
                4'd4:    val = 9'd120;
                4'd5:    val = 9'd151;
                4'd6:    val = 9'd181;
                4'd7:    val = 9'd212;
                4'd8:    val = 9'd243;
                4'd9:    val = 9'd273;
                4'd10:   val = 9'd304;
                4'd11:   val = 9'd334;
                4'd12:   val = 9'd365;
                default: val = 9'd365;
            endcase
            return val;
        end
    endfunction

endpackage

FILE: hdl/epoch_seconds_to_calendar_core.sv
// ----------------------------------------------------------------------------
// Epoch seconds to calendar converter
// Eight-stage pipeline that splits a signed 32-bit second count since
// 1970-01-01 00:00:00 into year, month, day, weekday, day of year and time.
// ----------------------------------------------------------------------------
// Usage:
//   A word enters on the time channel (time_valid, time_stall, epoch_seconds)
//   and its calendar breakdown leaves on the cal channel (cal_valid,
//   cal_stall and the result fields). A word is taken at a clock edge where
//   valid is high and stall is low.
//   The result fields are registered in the last stage, whose valid bit is
//   cal_valid. One word can be taken in every cycle while the receiver does
//   not stall; on any one path a stage holds at most one multiplication by
//   a constant reciprocal or one subtract-and-correct step; that sets depth.
//   Each stage has its own valid bit and moves whenever the stage after it
//   can take its word, so bubbles close up. When the receiver stalls, the
//   last stage holds its word, the stages behind it fill, and time_stall
//   rises only once every stage holds a word. Nothing is lost or repeated.
//   A negative input gives all-zero fields with negative_input set.
//   Reset empties every stage; the payload registers are not cleared.
//   Years are exact through the end of the 32-bit range in 2038.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               time_valid,
    output logic               time_stall,
    input  logic signed [31:0] epoch_seconds,
    output logic               cal_valid,
    input  logic               cal_stall,
    output logic        [10:0] year,
    output logic        [3:0]  month,
    output logic        [4:0]  day_of_month,
    output logic        [2:0]  weekday,
    output logic        [8:0]  day_of_year,
    output logic        [4:0]  hour,
    output logic        [5:0]  minute,
    output logic        [5:0]  second,
    output logic               negative_input
);
    import epcal_pkg::*;

    // ------------------------------------------------------------------
    // Stage valid bits and enables
    // ------------------------------------------------------------------
    logic [8:1] valid_reg;
    logic [8:1] en;

    // A stage loads when it is empty or its word moves on.
    always_comb
    begin
        en[8] = !valid_reg[8] || !cal_stall;
        for (int k = 7; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k + 1];
        end
    end

    assign time_stall = !en[1];
    assign cal_valid  = valid_reg[8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= time_valid;
            end
            for (int k = 2; k <= 8; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: split off the low seven bits of the second count.
    // ------------------------------------------------------------------
    logic [23:0] s1_hi_reg;
    logic [6:0]  s1_lo_reg;
    logic        s1_neg_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_hi_reg  <= epoch_seconds[30:DAY_LO_BITS];
            s1_lo_reg  <= epoch_seconds[DAY_LO_BITS-1:0];
            s1_neg_reg <= epoch_seconds[31];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: estimate whole days by the reciprocal of 675.
    // ------------------------------------------------------------------
    logic [48:0] s2_prod;
    logic [14:0] s2_days_est_next;
    logic [14:0] s2_days_est_reg;
    logic [23:0] s2_hi_reg;
    logic [6:0]  s2_lo_reg;
    logic        s2_neg_reg;

    always_comb
    begin
        s2_prod          = 49'(s1_hi_reg) * 49'(DAY_RECIP);
        s2_days_est_next = s2_prod[48:DAY_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_days_est_reg <= s2_days_est_next;
            s2_hi_reg       <= s1_hi_reg;
            s2_lo_reg       <= s1_lo_reg;
            s2_neg_reg      <= s1_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: correct the day estimate and form the second of the day.
    // ------------------------------------------------------------------
    logic [23:0] s3_rem;
    logic        s3_fix;
    logic [14:0] s3_days_next;
    logic [16:0] s3_secs_next;
    logic [9:0]  s3_rem_fixed;
    logic [14:0] s3_days_reg;
    logic [16:0] s3_secs_reg;
    logic        s3_neg_reg;

    always_comb
    begin
        s3_rem       = s2_hi_reg - 24'(s2_days_est_reg) * 24'(DAY_HI_DIV);
        s3_fix       = (s3_rem >= 24'(DAY_HI_DIV));
        s3_days_next = s2_days_est_reg + 15'(s3_fix);
        s3_rem_fixed = s3_fix ? 10'(s3_rem - 24'(DAY_HI_DIV)) : s3_rem[9:0];
        s3_secs_next = {s3_rem_fixed, s2_lo_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_days_reg <= s3_days_next;
            s3_secs_reg <= s3_secs_next;
            s3_neg_reg  <= s2_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: estimate cycles, weeks and hours in parallel.
    // ------------------------------------------------------------------
    logic [28:0] s4_cyc_prod;
    logic [14:0] s4_wk_n_next;
    logic [29:0] s4_wk_prod;
    logic [26:0] s4_hr_prod;
    logic [4:0]  s4_cyc_est_reg;
    logic [11:0] s4_wk_est_reg;
    logic [4:0]  s4_hr_est_reg;
    logic [14:0] s4_days_reg;
    logic [14:0] s4_wk_n_reg;
    logic [16:0] s4_secs_reg;
    logic        s4_neg_reg;

    always_comb
    begin
        s4_cyc_prod  = 29'(s3_days_reg) * 29'(CYC_RECIP);
        s4_wk_n_next = s3_days_reg + WK_OFFSET;
        s4_wk_prod   = 30'(s4_wk_n_next) * 30'(WK_RECIP);
        s4_hr_prod   = 27'(s3_secs_reg) * 27'(HR_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_cyc_est_reg <= s4_cyc_prod[28:CYC_SHIFT];
            s4_wk_est_reg  <= s4_wk_prod[29:WK_SHIFT];
            s4_hr_est_reg  <= s4_hr_prod[26:HR_SHIFT];
            s4_days_reg    <= s3_days_reg;
            s4_wk_n_reg    <= s4_wk_n_next;
            s4_secs_reg    <= s3_secs_reg;
            s4_neg_reg     <= s3_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: correct the estimates; remainders give day in cycle,
    // weekday and second within the hour.
    // ------------------------------------------------------------------
    logic [14:0] s5_ic_rem;
    logic        s5_ic_fix;
    logic [14:0] s5_wk_rem;
    logic        s5_wk_fix;
    logic [16:0] s5_hr_rem;
    logic        s5_hr_fix;
    logic [4:0]  s5_cycles_next;
    logic [10:0] s5_in_cycle_next;
    logic [2:0]  s5_weekday_next;
    logic [4:0]  s5_hour_next;
    logic [11:0] s5_sih_next;
    logic [4:0]  s5_cycles_reg;
    logic [10:0] s5_in_cycle_reg;
    logic [2:0]  s5_weekday_reg;
    logic [4:0]  s5_hour_reg;
    logic [11:0] s5_sih_reg;
    logic        s5_neg_reg;

    always_comb
    begin
        s5_ic_rem = s4_days_reg - 15'(s4_cyc_est_reg) * 15'(DAYS_PER_CYCLE);
        s5_ic_fix = (s5_ic_rem >= 15'(DAYS_PER_CYCLE));
        s5_cycles_next   = s4_cyc_est_reg + 5'(s5_ic_fix);
        s5_in_cycle_next = s5_ic_fix ? 11'(s5_ic_rem - 15'(DAYS_PER_CYCLE))
                                     : s5_ic_rem[10:0];

        s5_wk_rem = s4_wk_n_reg - 15'(s4_wk_est_reg) * 15'(DAYS_PER_WEEK);
        s5_wk_fix = (s5_wk_rem >= 15'(DAYS_PER_WEEK));
        s5_weekday_next = s5_wk_fix ? 3'(s5_wk_rem - 15'(DAYS_PER_WEEK))
                                    : s5_wk_rem[2:0];

        s5_hr_rem = s4_secs_reg - 17'(s4_hr_est_reg) * 17'(SECS_PER_HOUR);
        s5_hr_fix = (s5_hr_rem >= 17'(SECS_PER_HOUR));
        s5_hour_next = s4_hr_est_reg + 5'(s5_hr_fix);
        s5_sih_next  = s5_hr_fix ? 12'(s5_hr_rem - 17'(SECS_PER_HOUR))
                                 : s5_hr_rem[11:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_cycles_reg   <= s5_cycles_next;
            s5_in_cycle_reg <= s5_in_cycle_next;
            s5_weekday_reg  <= s5_weekday_next;
            s5_hour_reg     <= s5_hour_next;
            s5_sih_reg      <= s5_sih_next;
            s5_neg_reg      <= s4_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: find the year within the cycle and estimate minutes.
    // ------------------------------------------------------------------
    logic [1:0]  s6_yidx_next;
    logic [10:0] s6_doy_wide;
    logic [21:0] s6_min_prod;
    logic [1:0]  s6_yidx_reg;
    logic [8:0]  s6_doy_reg;
    logic [5:0]  s6_min_est_reg;
    logic [4:0]  s6_cycles_reg;
    logic [2:0]  s6_weekday_reg;
    logic [4:0]  s6_hour_reg;
    logic [11:0] s6_sih_reg;
    logic        s6_neg_reg;

    always_comb
    begin
        if (s5_in_cycle_reg < YEAR1_START)
        begin
            s6_yidx_next = 2'd0;
            s6_doy_wide  = s5_in_cycle_reg;
        end
        else if (s5_in_cycle_reg < YEAR2_START)
        begin
            s6_yidx_next = 2'd1;
            s6_doy_wide  = s5_in_cycle_reg - YEAR1_START;
        end
        else if (s5_in_cycle_reg < YEAR3_START)
        begin
            s6_yidx_next = 2'd2;
            s6_doy_wide  = s5_in_cycle_reg - YEAR2_START;
        end
        else
        begin
            s6_yidx_next = 2'd3;
            s6_doy_wide  = s5_in_cycle_reg - YEAR3_START;
        end
        s6_min_prod = 22'(s5_sih_reg) * 22'(MIN_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_yidx_reg    <= s6_yidx_next;
            s6_doy_reg     <= s6_doy_wide[8:0];
            s6_min_est_reg <= s6_min_prod[21:MIN_SHIFT];
            s6_cycles_reg  <= s5_cycles_reg;
            s6_weekday_reg <= s5_weekday_reg;
            s6_hour_reg    <= s5_hour_reg;
            s6_sih_reg     <= s5_sih_reg;
            s6_neg_reg     <= s5_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: form the year and leap flags, finish minute and second.
    // The leap year is third in each cycle; within the covered range the
    // only century year, 2000, is a multiple of 400 and so stays leap.
    // ------------------------------------------------------------------
    logic        s7_leap;
    logic [10:0] s7_year_next;
    logic        s7_leap_day_next;
    logic [8:0]  s7_nl_next;
    logic [11:0] s7_min_rem;
    logic        s7_min_fix;
    logic [5:0]  s7_minute_next;
    logic [5:0]  s7_second_next;
    logic [10:0] s7_year_reg;
    logic        s7_leap_day_reg;
    logic [8:0]  s7_nl_reg;
    logic [8:0]  s7_doy_reg;
    logic [2:0]  s7_weekday_reg;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_minute_reg;
    logic [5:0]  s7_second_reg;
    logic        s7_neg_reg;

    always_comb
    begin
        s7_year_next     = BASE_YEAR + 11'({s6_cycles_reg, s6_yidx_reg});
        s7_leap          = (s6_yidx_reg == LEAP_YEAR_IDX);
        s7_leap_day_next = s7_leap && (s6_doy_reg == LEAP_DAY_INDEX);
        s7_nl_next       = s6_doy_reg
                           - 9'(s7_leap && (s6_doy_reg > LEAP_DAY_INDEX));

        s7_min_rem = s6_sih_reg - 12'(s6_min_est_reg) * 12'(SECS_PER_MIN);
        s7_min_fix = (s7_min_rem >= 12'(SECS_PER_MIN));
        s7_minute_next = s6_min_est_reg + 6'(s7_min_fix);
        s7_second_next = s7_min_fix ? 6'(s7_min_rem - 12'(SECS_PER_MIN))
                                    : s7_min_rem[5:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_year_reg     <= s7_year_next;
            s7_leap_day_reg <= s7_leap_day_next;
            s7_nl_reg       <= s7_nl_next;
            s7_doy_reg      <= s6_doy_reg;
            s7_weekday_reg  <= s6_weekday_reg;
            s7_hour_reg     <= s6_hour_reg;
            s7_minute_reg   <= s7_minute_next;
            s7_second_reg   <= s7_second_next;
            s7_neg_reg      <= s6_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: look up the month and day, zero everything for a negative
    // input, and hold the result word for the receiver.
    // ------------------------------------------------------------------
    logic [3:0]  s8_month;
    logic [8:0]  s8_mday_wide;
    logic [4:0]  s8_mday;
    logic [10:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_of_month_reg;
    logic [2:0]  weekday_reg;
    logic [8:0]  day_of_year_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic        negative_input_reg;

    always_comb
    begin
        // First month whose end lies beyond the adjusted day.
        s8_month = MONTH_DEC;
        for (int i = MONTHS - 1; i >= 0; i--)
        begin
            if (s7_nl_reg < month_start(4'(i + 1)))
            begin
                s8_month = 4'(i);
            end
        end
        s8_mday_wide = s7_nl_reg - month_start(s8_month);
        s8_mday      = s8_mday_wide[4:0];

        // The 29th of February stands outside the common-year table.
        if (s7_leap_day_reg)
        begin
            s8_month = MONTH_FEB;
            s8_mday  = FEB_LAST_DAY;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            if (s7_neg_reg)
            begin
                year_reg         <= '0;
                month_reg        <= '0;
                day_of_month_reg <= '0;
                weekday_reg      <= '0;
                day_of_year_reg  <= '0;
                hour_reg         <= '0;
                minute_reg       <= '0;
                second_reg       <= '0;
            end
            else
            begin
                year_reg         <= s7_year_reg;
                month_reg        <= s8_month;
                day_of_month_reg <= s8_mday;
                weekday_reg      <= s7_weekday_reg;
                day_of_year_reg  <= s7_doy_reg;
                hour_reg         <= s7_hour_reg;
                minute_reg       <= s7_minute_reg;
                second_reg       <= s7_second_reg;
            end
            negative_input_reg <= s7_neg_reg;
        end
    end

    assign year           = year_reg;
    assign month          = month_reg;
    assign day_of_month   = day_of_month_reg;
    assign weekday        = weekday_reg;
    assign day_of_year    = day_of_year_reg;
    assign hour           = hour_reg;
    assign minute         = minute_reg;
    assign second         = second_reg;
    assign negative_input = negative_input_reg;

endmodule
